// File: sv/mdda_pkg.sv
// Shared types and constants for the multi-axis DDA step generator.
package mdda_pkg;

  localparam int AXES   = 8;
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int CNT_W  = $clog2(AXES + 1);
  localparam int TGT_W  = 32;
  localparam int MAG_W  = 31;
  localparam int ACC_W  = 32;
  localparam int MA_W   = MAG_W + ACC_W;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [ACC_W-1:0] acc;
    logic             step;
  } alu_res_t;

endpackage

// File: sv/mdda_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mdda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/mdda_axis_alu.sv
// Per-axis arithmetic: target magnitude and Bresenham accumulate step.
module mdda_axis_alu import mdda_pkg::*; (
  input  logic signed [TGT_W-1:0] tgt,
  input  logic [MAG_W-1:0]        mag,
  input  logic [ACC_W-1:0]        acc,
  input  logic [MAG_W-1:0]        ctrl,
  output alu_res_t                res
);

  logic [TGT_W-1:0] tneg;
  logic [ACC_W-1:0] sum;
  logic [ACC_W-1:0] ctrl_ext;
  logic             ge;

  always_comb begin
    tneg     = TGT_W'(~tgt) + TGT_W'(1);
    sum      = acc + {1'b0, mag};
    ctrl_ext = {1'b0, ctrl};
    ge       = (sum >= ctrl_ext);

    res.neg  = tgt[TGT_W-1];
    if (!tgt[TGT_W-1]) begin
      res.mag = tgt[MAG_W-1:0];
    end else if (tneg[TGT_W-1]) begin
      res.mag = MAG_MAX;  // most negative target saturates
    end else begin
      res.mag = tneg[MAG_W-1:0];
    end
    res.step = ge;
    res.acc  = ge ? (sum - ctrl_ext) : sum;
  end

endmodule

// File: sv/multi_axis_dda_step_generator.sv
// Top level: request sequencer around target and magnitude/accumulator memories.
//
// Input channel (in_valid/in_ready) carries requests: op 0 loads the signed
// target of one axis, op 1 starts a move, op 2 is a step tick, op 3 is
// ignored. Only ticks produce a result on the output channel
// (out_valid/out_ready): the step and direction masks, one bit per axis.
// Requests are taken only while the sequencer is idle.
// Load: the target is written and the sequencer stays idle. Start: one target
// memory read per axis, data back in the next cycle. Tick: one read-modify-write
// of the accumulator memory per axis; the result is registered in the emit state,
// and the next request can be taken after that. With no move set up (control
// magnitude zero) a tick skips the sweep and emits zero step bits.
// The output register holds one result; a new load or start is taken while it
// waits. A tick that finishes while the result is still not taken holds in
// its final state until the receiver takes it.
// Reset clears targets (via per-axis valid bits), the control magnitude,
// direction bits and any pending result; there is no clearing pass.
module multi_axis_dda_step_generator import mdda_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [2:0]              in_axis,
  input  logic signed [TGT_W-1:0] in_target_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_steps,
  output logic [7:0]              out_dirs
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              pend_r, pend_nxt;
  logic [AXIS_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [MAG_W-1:0]  ctrl_mag_r, ctrl_mag_nxt;
  logic [AXES-1:0]   dir_r, dir_nxt;
  logic [AXES-1:0]   bits_r, bits_nxt;
  logic [AXES-1:0]   tv_r, tv_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AXES-1:0]   out_step_r, out_step_nxt;
  logic [AXES-1:0]   out_dir_r, out_dir_nxt;

  logic              in_fire;
  logic              last;
  logic              out_load;
  logic              tgt_we;
  logic [TGT_W-1:0]  tgt_rdata;
  logic              rd_en;
  logic [AXIS_W-1:0] rd_addr;
  logic              ma_we;
  logic [MA_W-1:0]   ma_wdata;
  logic [MA_W-1:0]   ma_rdata;
  logic [MAG_W-1:0]  ma_mag;
  logic [ACC_W-1:0]  ma_acc;
  logic [TGT_W-1:0]  tgt_eff;
  alu_res_t          alu;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_en    = (issue_r < CNT_W'(AXES)) && (state_r == ST_START || state_r == ST_TICK);
  assign rd_addr  = issue_r[AXIS_W-1:0];
  assign last     = pend_r && (pend_idx_r == AXIS_W'(AXES - 1));
  assign tgt_we   = in_fire && (op_t'(in_op) == OP_LOAD) && ({1'b0, in_axis} < 4'(AXES));
  assign ma_mag   = ma_rdata[MA_W-1:ACC_W];
  assign ma_acc   = ma_rdata[ACC_W-1:0];
  assign tgt_eff  = tv_r[pend_idx_r] ? tgt_rdata : '0;
  assign ma_we    = pend_r && (state_r == ST_START || state_r == ST_TICK);
  assign ma_wdata = (state_r == ST_START) ? {alu.mag, {ACC_W{1'b0}}} : {ma_mag, alu.acc};
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  mdda_ram #(.WIDTH(TGT_W), .DEPTH(AXES)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (in_axis[AXIS_W-1:0]),
    .wdata (in_target_value),
    .re    (rd_en && (state_r == ST_START)),
    .raddr (rd_addr),
    .rdata (tgt_rdata)
  );

  mdda_ram #(.WIDTH(MA_W), .DEPTH(AXES)) u_ma_ram (
    .clk   (clk),
    .we    (ma_we),
    .waddr (pend_idx_r),
    .wdata (ma_wdata),
    .re    (rd_en && (state_r == ST_TICK)),
    .raddr (rd_addr),
    .rdata (ma_rdata)
  );

  mdda_axis_alu u_alu (
    .tgt  ($signed(tgt_eff)),
    .mag  (ma_mag),
    .acc  (ma_acc),
    .ctrl (ctrl_mag_r),
    .res  (alu)
  );

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    ctrl_mag_nxt  = ctrl_mag_r;
    dir_nxt       = dir_r;
    bits_nxt      = bits_r;
    tv_nxt        = tv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_step_nxt  = out_step_r;
    out_dir_nxt   = out_dir_r;

    if (tgt_we) begin
      tv_nxt[in_axis[AXIS_W-1:0]] = 1'b1;
    end

    if (rd_en) begin
      issue_nxt    = issue_r + CNT_W'(1);
      pend_nxt     = 1'b1;
      pend_idx_nxt = rd_addr;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(in_op))
            OP_START: begin
              state_nxt    = ST_START;
              issue_nxt    = '0;
              ctrl_mag_nxt = '0;
              dir_nxt      = '0;
            end
            OP_TICK: begin
              bits_nxt  = '0;
              issue_nxt = '0;
              state_nxt = (ctrl_mag_r == '0) ? ST_EMIT : ST_TICK;
            end
            OP_LOAD, OP_NONE: begin
            end
          endcase
        end
      end
      ST_START: begin
        if (pend_r) begin
          if (alu.neg) begin
            dir_nxt[pend_idx_r] = 1'b1;
          end
          if (alu.mag > ctrl_mag_r) begin
            ctrl_mag_nxt = alu.mag;
          end
        end
        if (last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (pend_r && alu.step) begin
          bits_nxt[pend_idx_r] = 1'b1;
        end
        if (last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_step_nxt  = bits_r;
          out_dir_nxt   = dir_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      ctrl_mag_r  <= '0;
      dir_r       <= '0;
      tv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      ctrl_mag_r  <= ctrl_mag_nxt;
      dir_r       <= dir_nxt;
      tv_r        <= tv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    bits_r     <= bits_nxt;
    out_step_r <= out_step_nxt;
    out_dir_r  <= out_dir_nxt;
  end

  always_comb begin
    out_steps = '0;
    out_dirs  = '0;
    for (int a = 0; a < AXES; a++) begin
      out_steps[a] = out_step_r[a];
      out_dirs[a]  = out_dir_r[a];
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ma_we && state_r == ST_TICK) |-> (alu.acc < {1'b0, ctrl_mag_r}))
    else $error("accumulator not below control magnitude");

  a_tick_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (ctrl_mag_r != '0))
    else $error("tick sweep with zero control magnitude");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= CNT_W'(AXES))
    else $error("issue counter out of range");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("emitted result not registered");
`endif

endmodule
